// File: design/cds_pkg.sv
// ----------------------------------------------------------------------------
// cds_pkg
// Shared widths, codes, configuration record and helpers for the
// critically damped spring step block.
// ----------------------------------------------------------------------------
`default_nettype none

package cds_pkg;

    localparam int FRAC_BITS  = 16;

    localparam int FUNC_W     = 2;
    localparam int SHOTS_W    = 24;
    localparam int POS_W      = 23;
    localparam int VEL_W      = 26;
    localparam int COEF_W     = 18;
    localparam int GAIN_W     = 18;
    localparam int THR_W      = 16;
    localparam int CFG_DATA_W = 23;
    localparam int CFG_IDX_W  = 3;

    localparam int PROD_W     = COEF_W + VEL_W;
    localparam int SUM_W      = PROD_W + 1;
    localparam int FIRE_W     = POS_W + GAIN_W;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_FIRE  = 2'd1,
        FUNC_CLEAR = 2'd2
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KICK_GAIN      = 3'd0,
        CFG_COEF_POS_POS   = 3'd1,
        CFG_COEF_POS_VEL   = 3'd2,
        CFG_COEF_VEL_POS   = 3'd3,
        CFG_COEF_VEL_VEL   = 3'd4,
        CFG_MAX_AMPLITUDE  = 3'd5,
        CFG_REST_THRESHOLD = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic        [GAIN_W-1:0] kick_gain;
        logic signed [COEF_W-1:0] coef_pos_pos;
        logic signed [COEF_W-1:0] coef_pos_vel;
        logic signed [COEF_W-1:0] coef_vel_pos;
        logic signed [COEF_W-1:0] coef_vel_vel;
        logic        [POS_W-1:0]  max_amplitude;
        logic        [THR_W-1:0]  rest_threshold;
    } cfg_t;

    localparam logic        [GAIN_W-1:0] KICK_GAIN_RST      = 18'd59382;
    localparam logic signed [COEF_W-1:0] COEF_POS_POS_RST   = 18'sd62611;
    localparam logic signed [COEF_W-1:0] COEF_POS_VEL_RST   = 18'sd46959;
    localparam logic signed [COEF_W-1:0] COEF_VEL_POS_RST   = -18'sd5218;
    localparam logic signed [COEF_W-1:0] COEF_VEL_VEL_RST   = 18'sd31306;
    localparam logic        [POS_W-1:0]  MAX_AMPLITUDE_RST  = 23'd262144;
    localparam logic        [THR_W-1:0]  REST_THRESHOLD_RST = 16'd7;

    // saturate a wide signed sum to the velocity range
    function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [SUM_W-1:0] v);
        logic signed [VEL_W-1:0] r;
        if (v[SUM_W-1:VEL_W-1] == '0 || v[SUM_W-1:VEL_W-1] == '1)
        begin
            r = v[VEL_W-1:0];
        end
        else if (v[SUM_W-1])
        begin
            r = {1'b1, {(VEL_W-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(VEL_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: design/cds_cmd_if.sv
// ----------------------------------------------------------------------------
// cds_cmd_if
// Command channel: function code and shot strength, valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface cds_cmd_if;
    import cds_pkg::*;

    logic                      valid;
    logic                      ready;
    logic        [FUNC_W-1:0]  func;
    logic signed [SHOTS_W-1:0] shots;

    modport source (output valid, output func, output shots, input ready);
    modport sink   (input valid, input func, input shots, output ready);
endinterface

`default_nettype wire

// File: design/cds_res_if.sv
// ----------------------------------------------------------------------------
// cds_res_if
// Result channel: position after each command word, valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface cds_res_if;
    import cds_pkg::*;

    logic             valid;
    logic             ready;
    logic [POS_W-1:0] amplitude;

    modport source (output valid, output amplitude, input ready);
    modport sink   (input valid, input amplitude, output ready);
endinterface

`default_nettype wire

// File: design/cds_cfg_regs.sv
// ----------------------------------------------------------------------------
// cds_cfg_regs
// Configuration register file, write-only, indexed.
// ----------------------------------------------------------------------------
`default_nettype none

module cds_cfg_regs (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [cds_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [cds_pkg::CFG_DATA_W-1:0]   cfg_data,
    output cds_pkg::cfg_t                         cfg
);
    import cds_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_KICK_GAIN:      cfg_next.kick_gain      = cfg_data[GAIN_W-1:0];
                CFG_COEF_POS_POS:   cfg_next.coef_pos_pos   = signed'(cfg_data[COEF_W-1:0]);
                CFG_COEF_POS_VEL:   cfg_next.coef_pos_vel   = signed'(cfg_data[COEF_W-1:0]);
                CFG_COEF_VEL_POS:   cfg_next.coef_vel_pos   = signed'(cfg_data[COEF_W-1:0]);
                CFG_COEF_VEL_VEL:   cfg_next.coef_vel_vel   = signed'(cfg_data[COEF_W-1:0]);
                CFG_MAX_AMPLITUDE:  cfg_next.max_amplitude  = cfg_data[POS_W-1:0];
                CFG_REST_THRESHOLD: cfg_next.rest_threshold = cfg_data[THR_W-1:0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kick_gain      <= KICK_GAIN_RST;
            cfg_reg.coef_pos_pos   <= COEF_POS_POS_RST;
            cfg_reg.coef_pos_vel   <= COEF_POS_VEL_RST;
            cfg_reg.coef_vel_pos   <= COEF_VEL_POS_RST;
            cfg_reg.coef_vel_vel   <= COEF_VEL_VEL_RST;
            cfg_reg.max_amplitude  <= MAX_AMPLITUDE_RST;
            cfg_reg.rest_threshold <= REST_THRESHOLD_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: design/cds_core.sv
// ----------------------------------------------------------------------------
// cds_core
// Spring state (position, velocity) and the one-pass update for tick,
// fire and clear.
// ----------------------------------------------------------------------------
`default_nettype none

module cds_core (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             step,
    input  wire logic [cds_pkg::FUNC_W-1:0]       func,
    input  wire logic signed [cds_pkg::SHOTS_W-1:0] shots,
    input  wire cds_pkg::cfg_t                    cfg,
    output logic [cds_pkg::POS_W-1:0]             pos_next
);
    import cds_pkg::*;

    logic        [POS_W-1:0]  pos_reg;
    logic signed [VEL_W-1:0]  vel_reg;
    logic signed [VEL_W-1:0]  vel_next;

    logic signed [POS_W:0]    pos_s;
    logic signed [PROD_W-1:0] prod_pp;
    logic signed [PROD_W-1:0] prod_pv;
    logic signed [PROD_W-1:0] prod_vp;
    logic signed [PROD_W-1:0] prod_vv;
    logic signed [SUM_W-1:0]  nx_full;
    logic signed [SUM_W-1:0]  nv_full;
    logic signed [SUM_W-1:0]  max_ext;
    logic signed [VEL_W-1:0]  nv_sat;
    logic        [POS_W-1:0]  nx_clamp;
    logic signed [VEL_W-1:0]  nv_clamp;
    logic signed [VEL_W:0]    nv_w;
    logic signed [VEL_W:0]    thr_w;
    logic                     at_rest;

    logic                     shot_pos;
    logic        [POS_W-1:0]  shot_mag;
    logic        [FIRE_W-1:0] fire_prod;
    logic signed [SUM_W-1:0]  fire_sum;

    // tick: 2x2 map, floor shift, saturate, clamp to range, rest check
    assign pos_s   = signed'({1'b0, pos_reg});
    assign prod_pp = PROD_W'(cfg.coef_pos_pos) * PROD_W'(pos_s);
    assign prod_pv = PROD_W'(cfg.coef_pos_vel) * PROD_W'(vel_reg);
    assign prod_vp = PROD_W'(cfg.coef_vel_pos) * PROD_W'(pos_s);
    assign prod_vv = PROD_W'(cfg.coef_vel_vel) * PROD_W'(vel_reg);
    assign nx_full = (SUM_W'(prod_pp) + SUM_W'(prod_pv)) >>> FRAC_BITS;
    assign nv_full = (SUM_W'(prod_vp) + SUM_W'(prod_vv)) >>> FRAC_BITS;
    assign nv_sat  = sat_vel(nv_full);
    assign max_ext = signed'(SUM_W'(cfg.max_amplitude));

    always_comb
    begin
        nx_clamp = nx_full[POS_W-1:0];
        nv_clamp = nv_sat;
        if (nx_full[SUM_W-1])
        begin
            nx_clamp = '0;
            if (nv_sat[VEL_W-1])
            begin
                nv_clamp = '0;
            end
        end
        else if (nx_full > max_ext)
        begin
            nx_clamp = cfg.max_amplitude;
            if (!nv_sat[VEL_W-1] && nv_sat != '0)
            begin
                nv_clamp = '0;
            end
        end
    end

    assign nv_w    = (VEL_W+1)'(nv_clamp);
    assign thr_w   = signed'((VEL_W+1)'(cfg.rest_threshold));
    assign at_rest = (nx_clamp < POS_W'(cfg.rest_threshold)) && (nv_w > -thr_w) && (nv_w < thr_w);

    // fire: clamp strength, scale by gain, add to velocity
    assign shot_pos  = !shots[SHOTS_W-1] && (shots != '0);
    assign shot_mag  = (shots[POS_W-1:0] > cfg.max_amplitude) ? cfg.max_amplitude
                                                              : shots[POS_W-1:0];
    assign fire_prod = FIRE_W'(shot_mag) * FIRE_W'(cfg.kick_gain);
    assign fire_sum  = SUM_W'(vel_reg) + signed'(SUM_W'(fire_prod >> FRAC_BITS));

    always_comb
    begin
        pos_next = pos_reg;
        vel_next = vel_reg;
        case (func_t'(func))
            FUNC_TICK:
            begin
                pos_next = at_rest ? '0 : nx_clamp;
                vel_next = at_rest ? '0 : nv_clamp;
            end
            FUNC_FIRE:
            begin
                if (shot_pos)
                begin
                    vel_next = sat_vel(fire_sum);
                end
            end
            FUNC_CLEAR:
            begin
                pos_next = '0;
                vel_next = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            vel_reg <= '0;
        end
        else if (step)
        begin
            pos_reg <= pos_next;
            vel_reg <= vel_next;
        end
    end

endmodule

`default_nettype wire

// File: design/critically_damped_spring_step.sv
// ----------------------------------------------------------------------------
// critically_damped_spring_step
// Flow: an accepted command word is registered in the input stage; the
// updated position is then registered as the result word, held until taken.
// Throughput: one word per cycle while res.ready does not stall the output;
// the tick update is combinational via four parallel multipliers in cds_core.
// Reset: state cleared to rest, config registers to defaults, channels empty.
// ----------------------------------------------------------------------------
`default_nettype none

module critically_damped_spring_step (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    cds_cmd_if.sink                             cmd,
    cds_res_if.source                           res,
    input  wire logic                           cfg_we,
    input  wire logic [cds_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [cds_pkg::CFG_DATA_W-1:0] cfg_data
);
    import cds_pkg::*;

    cfg_t                      cfg;

    logic                      in_vld_reg;
    logic                      in_vld_next;
    logic        [FUNC_W-1:0]  func_reg;
    logic signed [SHOTS_W-1:0] shots_reg;
    logic                      out_vld_reg;
    logic                      out_vld_next;
    logic        [POS_W-1:0]   amp_reg;
    logic        [POS_W-1:0]   pos_next;
    logic                      advance;
    logic                      step;
    logic                      cmd_acc;

    cds_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cds_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .func     (func_reg),
        .shots    (shots_reg),
        .cfg      (cfg),
        .pos_next (pos_next)
    );

    assign advance   = !out_vld_reg || res.ready;
    assign step      = in_vld_reg && advance;
    assign cmd.ready = !in_vld_reg || advance;
    assign cmd_acc   = cmd.valid && cmd.ready;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (cmd_acc)
        begin
            in_vld_next = 1'b1;
        end
        else if (step)
        begin
            in_vld_next = 1'b0;
        end

        out_vld_next = out_vld_reg;
        if (step)
        begin
            out_vld_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_acc)
        begin
            func_reg  <= cmd.func;
            shots_reg <= cmd.shots;
        end
        if (step)
        begin
            amp_reg <= pos_next;
        end
    end

    assign res.valid     = out_vld_reg;
    assign res.amplitude = amp_reg;

`ifndef SYNTHESIS
    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        step && func_reg == FUNC_CLEAR |=> res.valid && res.amplitude == '0)
        else $error("clear word did not return zero position");

    a_tick_bound: assert property (@(posedge clk) disable iff (!rst_n)
        step && func_reg == FUNC_TICK |=> res.amplitude <= $past(cfg.max_amplitude))
        else $error("tick position above clamp");

    a_cmd_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_acc |=> in_vld_reg)
        else $error("accepted command word lost");
`endif

endmodule

`default_nettype wire
